// File: hdl/clipped_colour_key_blitter_unit_defines.svh
// ---------------------------------------------------------------------------
// Clipped colour-key blitter: assertion macros
// Shared property forms on clk with the asynchronous reset masking them.
// ---------------------------------------------------------------------------
`ifndef CLIPPED_COLOUR_KEY_BLITTER_UNIT_DEFINES_SVH
`define CLIPPED_COLOUR_KEY_BLITTER_UNIT_DEFINES_SVH

// Consequent holds in the same cycle as the antecedent.
`define CKB_ASSERT_NOW(label, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define CKB_ASSERT_NEXT(label, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// File: hdl/ckb_pkg.sv
// ---------------------------------------------------------------------------
// Clipped colour-key blitter: package
// Sizes, command and register codes, controller interface structs.
// ---------------------------------------------------------------------------
package ckb_pkg;

	localparam int MAX_WIDTH   = 256;
	localparam int MAX_HEIGHT  = 256;
	localparam int COORD_W     = 8;
	localparam int DIM_W       = 9;
	localparam int COLOUR_W    = 8;
	localparam int OFFSET_W    = 10;
	localparam int COUNT_W     = 17;
	localparam int CMD_W       = 2;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 9;
	localparam int CALC_W      = 12;
	localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int IN_DATA_W   = 80;
	localparam int OUT_DATA_W  = 32;

	localparam logic [CMD_W-1:0] CMD_LOAD_SRC = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD_DST = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ_DST = 2'd2;
	localparam logic [CMD_W-1:0] CMD_BLIT     = 2'd3;

	localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_WIDTH    = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_HEIGHT   = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_TARGET_WIDTH    = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_TARGET_HEIGHT   = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_TRANSPARENT_KEY = 3'd4;

	// controller to datapath
	typedef struct packed {
		logic capture;   // item accepted this cycle
		logic setup;     // register clip bounds, clear count
		logic walk;      // issue one pixel and advance
		logic out_load;  // load the output register
	} ckb_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic nonempty;  // clipped rectangle covers at least one pixel
		logic walk_last; // current pixel is the last one
	} ckb_status_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
			input logic [DIM_W-1:0] lim);
		return (v > lim) ? lim : v;
	endfunction

	function automatic logic [ADDR_W-1:0] pix_addr(input logic [COORD_W-1:0] x,
			input logic [COORD_W-1:0] y);
		return {y, x};
	endfunction

endpackage

// File: hdl/ckb_datapath.sv
// ---------------------------------------------------------------------------
// Clipped colour-key blitter: datapath
// Configuration registers, source and destination stores, clip bounds,
// pixel walk counters, keyed write pipeline and the result register.
// ---------------------------------------------------------------------------
module ckb_datapath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	input  logic [ckb_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [ckb_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic [ckb_pkg::CMD_W-1:0]          in_command,
	input  logic [ckb_pkg::IN_DATA_W-1:0]      in_data,
	input  ckb_pkg::ckb_cmd_t                  cmd,
	output ckb_pkg::ckb_status_t               status,
	output logic [ckb_pkg::COLOUR_W-1:0]       read_colour,
	output logic [ckb_pkg::COUNT_W-1:0]        written_count
);
	import ckb_pkg::*;

	localparam logic [DIM_W-1:0] MAX_W_D = DIM_W'(MAX_WIDTH);
	localparam logic [DIM_W-1:0] MAX_H_D = DIM_W'(MAX_HEIGHT);

	// configuration
	logic [DIM_W-1:0]    src_w_q, src_h_q, tgt_w_q, tgt_h_q;
	logic [COLOUR_W-1:0] key_q;
	logic [DIM_W-1:0]    sw, sh, tw, th;

	// input fields
	logic [COORD_W-1:0]         px, py, org_x, org_y;
	logic [COLOUR_W-1:0]        colour;
	logic signed [OFFSET_W-1:0] off_x, off_y;
	logic [DIM_W-1:0]           reg_w, reg_h;

	// captured blit fields
	logic [CMD_W-1:0]           kind_q;
	logic signed [OFFSET_W-1:0] ox_q, oy_q;
	logic [COORD_W-1:0]         sx0_q, sy0_q;
	logic [DIM_W-1:0]           rw_q, rh_q;

	// clip bounds
	logic signed [CALC_W-1:0] ox_e, oy_e, x_lo_c, y_lo_c, x_hi_c, y_hi_c;
	logic [COORD_W-1:0]       y_lo_q, x_q, y_q;
	logic [DIM_W-1:0]         x_hi_q, y_hi_q, x_next, y_next;
	logic                     x_end, y_end;

	// stores
	logic [COLOUR_W-1:0] src_mem [STORE_DEPTH];
	logic [COLOUR_W-1:0] tgt_mem [STORE_DEPTH];
	logic [COLOUR_W-1:0] src_rd_q, tgt_rd_q;
	logic                src_we, tgt_we, tgt_load, blit_we;
	logic [ADDR_W-1:0]   tgt_wa, src_ra;
	logic [COLOUR_W-1:0] tgt_wd;
	logic                rd_ok_q;

	// write pipeline
	logic                v_s1;
	logic [ADDR_W-1:0]   dst_s1;
	logic [COUNT_W-1:0]  count_q;

	logic [COLOUR_W-1:0] read_colour_q;
	logic [COUNT_W-1:0]  written_count_q;

	function automatic logic signed [CALC_W-1:0] min3(input logic signed [CALC_W-1:0] a,
			input logic signed [CALC_W-1:0] b, input logic signed [CALC_W-1:0] c);
		logic signed [CALC_W-1:0] m;
		m = (a < b) ? a : b;
		return (m < c) ? m : c;
	endfunction

	assign px     = in_data[7:0];
	assign py     = in_data[15:8];
	assign colour = in_data[23:16];
	assign off_x  = in_data[33:24];
	assign off_y  = in_data[43:34];
	assign org_x  = in_data[51:44];
	assign org_y  = in_data[59:52];
	assign reg_w  = in_data[68:60];
	assign reg_h  = in_data[77:69];

	assign sw = clamp_dim(src_w_q, MAX_W_D);
	assign sh = clamp_dim(src_h_q, MAX_H_D);
	assign tw = clamp_dim(tgt_w_q, MAX_W_D);
	assign th = clamp_dim(tgt_h_q, MAX_H_D);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= MAX_W_D;
			src_h_q <= MAX_H_D;
			tgt_w_q <= MAX_W_D;
			tgt_h_q <= MAX_H_D;
			key_q   <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_SOURCE_WIDTH:    src_w_q <= cfg_data;
				REG_SOURCE_HEIGHT:   src_h_q <= cfg_data;
				REG_TARGET_WIDTH:    tgt_w_q <= cfg_data;
				REG_TARGET_HEIGHT:   tgt_h_q <= cfg_data;
				REG_TRANSPARENT_KEY: key_q   <= cfg_data[COLOUR_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q  <= in_command;
			ox_q    <= off_x;
			oy_q    <= off_y;
			sx0_q   <= org_x;
			sy0_q   <= org_y;
			rw_q    <= reg_w;
			rh_q    <= reg_h;
			rd_ok_q <= ({1'b0, px} < tw) && ({1'b0, py} < th);
		end
	end

	// Clip: lower bound from a negative offset, upper bound from the
	// destination edge, the rectangle size and the source edge.
	assign ox_e   = CALC_W'(ox_q);
	assign oy_e   = CALC_W'(oy_q);
	assign x_lo_c = (ox_e < 0) ? -ox_e : '0;
	assign y_lo_c = (oy_e < 0) ? -oy_e : '0;
	assign x_hi_c = min3($signed(CALC_W'(tw)) - ox_e, $signed(CALC_W'(rw_q)),
		$signed(CALC_W'(sw)) - $signed(CALC_W'(sx0_q)));
	assign y_hi_c = min3($signed(CALC_W'(th)) - oy_e, $signed(CALC_W'(rh_q)),
		$signed(CALC_W'(sh)) - $signed(CALC_W'(sy0_q)));

	assign status.nonempty = (x_lo_c < x_hi_c) && (y_lo_c < y_hi_c);

	assign x_next = {1'b0, x_q} + DIM_W'(1);
	assign y_next = {1'b0, y_q} + DIM_W'(1);
	assign x_end  = (x_next == x_hi_q);
	assign y_end  = (y_next == y_hi_q);
	assign status.walk_last = x_end && y_end;

	// column outer, row inner
	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			y_lo_q <= y_lo_c[COORD_W-1:0];
			x_hi_q <= x_hi_c[DIM_W-1:0];
			y_hi_q <= y_hi_c[DIM_W-1:0];
			x_q    <= x_lo_c[COORD_W-1:0];
			y_q    <= y_lo_c[COORD_W-1:0];
		end else if (cmd.walk) begin
			if (y_end) begin
				y_q <= y_lo_q;
				x_q <= x_next[COORD_W-1:0];
			end else begin
				y_q <= y_next[COORD_W-1:0];
			end
		end
	end

	assign src_ra = pix_addr(sx0_q + x_q, sy0_q + y_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= cmd.walk;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.walk) begin
			dst_s1 <= pix_addr(x_q + ox_q[COORD_W-1:0], y_q + oy_q[COORD_W-1:0]);
		end
	end

	// drop transparent pixels
	assign blit_we = v_s1 && (src_rd_q != key_q);

	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			count_q <= '0;
		end else if (blit_we) begin
			count_q <= count_q + COUNT_W'(1);
		end
	end

	assign src_we = cmd.capture && (in_command == CMD_LOAD_SRC)
		&& ({1'b0, px} < sw) && ({1'b0, py} < sh);
	assign tgt_load = cmd.capture && (in_command == CMD_LOAD_DST)
		&& ({1'b0, px} < tw) && ({1'b0, py} < th);
	assign tgt_we = tgt_load || blit_we;
	assign tgt_wa = tgt_load ? pix_addr(px, py) : dst_s1;
	assign tgt_wd = tgt_load ? colour : src_rd_q;

	always_ff @(posedge clk) begin
		if (src_we) begin
			src_mem[pix_addr(px, py)] <= colour;
		end
		if (cmd.walk) begin
			src_rd_q <= src_mem[src_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (tgt_we) begin
			tgt_mem[tgt_wa] <= tgt_wd;
		end
		if (cmd.capture) begin
			tgt_rd_q <= tgt_mem[pix_addr(px, py)];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (cmd.capture) begin
				read_colour_q   <= '0;
				written_count_q <= '0;
			end else begin
				read_colour_q   <= (kind_q == CMD_READ_DST && rd_ok_q) ? tgt_rd_q : '0;
				written_count_q <= (kind_q == CMD_BLIT) ? count_q : '0;
			end
		end
	end

	assign read_colour   = read_colour_q;
	assign written_count = written_count_q;

endmodule

// File: hdl/ckb_controller.sv
// ---------------------------------------------------------------------------
// Clipped colour-key blitter: controller
// Sequences each item: loads finish at acceptance, reads pass a store read
// state, blits set up bounds, walk the pixels, drain and load the result.
// ---------------------------------------------------------------------------
`include "clipped_colour_key_blitter_unit_defines.svh"

module ckb_controller (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [ckb_pkg::CMD_W-1:0]  s_tuser,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	input  ckb_pkg::ckb_status_t       status,
	output ckb_pkg::ckb_cmd_t          cmd
);
	import ckb_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_READ  = 6'b000010,
		ST_SETUP = 6'b000100,
		ST_WALK  = 6'b001000,
		ST_DRAIN = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   m_tvalid_q;
	logic   accept;
	logic   is_load;

	assign s_tready = (state_q == ST_IDLE) && (!m_tvalid_q || m_tready);
	assign accept   = s_tvalid && s_tready;
	assign is_load  = (s_tuser == CMD_LOAD_SRC) || (s_tuser == CMD_LOAD_DST);

	assign cmd.capture  = accept;
	assign cmd.setup    = (state_q == ST_SETUP);
	assign cmd.walk     = (state_q == ST_WALK);
	assign cmd.out_load = (accept && is_load) || (state_q == ST_READ)
		|| (state_q == ST_DONE);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (s_tuser)
						CMD_READ_DST: state_d = ST_READ;
						CMD_BLIT:     state_d = ST_SETUP;
						default:      state_d = ST_IDLE;
					endcase
				end
			end
			ST_READ:  state_d = ST_IDLE;
			ST_SETUP: state_d = status.nonempty ? ST_WALK : ST_DRAIN;
			ST_WALK:  state_d = status.walk_last ? ST_DRAIN : ST_WALK;
			ST_DRAIN: state_d = ST_DONE;
			ST_DONE:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;

	`CKB_ASSERT_NOW(a_no_result_overwrite, cmd.out_load, !m_tvalid_q || m_tready, "result lost")
	`CKB_ASSERT_NEXT(a_blit_enters_setup, accept && s_tuser == CMD_BLIT, state_q == ST_SETUP, "blit skipped setup")
	`CKB_ASSERT_NEXT(a_drain_then_done, state_q == ST_DRAIN, state_q == ST_DONE && !s_tready, "drain did not finish")

endmodule

// File: hdl/clipped_colour_key_blitter_unit.sv
// ---------------------------------------------------------------------------
// Clipped colour-key blitter unit
// Palette-indexed blitter with source store, framebuffer, edge clipping
// and transparent colour key.
// ---------------------------------------------------------------------------
//  channel   handshake            payload
//  in        s_tvalid/s_tready    s_tuser command, s_tdata pixel and blit fields
//  out       m_tvalid/m_tready    m_tdata read_colour, written_count
//  config    cfg_valid/cfg_ready  cfg_index register, cfg_data value
//
//  Loads finish at acceptance; a read goes through a registered store read.
//  A blit walks one pixel of the clipped rectangle per cycle through the
//  single source read port, after acceptance and setup, then drains and
//  loads the result.
//  Reset clears control and configuration only; stores need no clearing pass.
//  A new item is taken once the previous result is gone or leaving.
// ---------------------------------------------------------------------------
module clipped_colour_key_blitter_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// [1:0] command
	input  logic [ckb_pkg::CMD_W-1:0]           s_tuser,
	// [7:0] pixel_x, [15:8] pixel_y, [23:16] pixel_colour, [33:24] offset_x,
	// [43:34] offset_y, [51:44] origin_x, [59:52] origin_y, [68:60] region_w,
	// [77:69] region_h, [79:78] zero
	input  logic [ckb_pkg::IN_DATA_W-1:0]       s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [7:0] read_colour, [24:8] written_count, [31:25] zero
	output logic [ckb_pkg::OUT_DATA_W-1:0]      m_tdata,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ckb_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [ckb_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import ckb_pkg::*;

	ckb_cmd_t            cmd;
	ckb_status_t         status;
	logic [COLOUR_W-1:0] read_colour;
	logic [COUNT_W-1:0]  written_count;

	assign cfg_ready = 1'b1;

	ckb_controller u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	ckb_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_command    (s_tuser),
		.in_data       (s_tdata),
		.cmd           (cmd),
		.status        (status),
		.read_colour   (read_colour),
		.written_count (written_count)
	);

	assign m_tdata = {(OUT_DATA_W - COUNT_W - COLOUR_W)'(0), written_count, read_colour};

endmodule
